### hw/rtl/msi_pkg.sv
// shared types, codes and constants for the motion safety interlock
package msi_pkg;

	localparam int BUMPER_COUNT = 8;
	localparam logic [7:0] BUMPER_ALL = 8'((9'd1 << BUMPER_COUNT) - 9'd1);
	localparam int DELTA_W = 26;
	localparam int PROD_W = 16 + DELTA_W;
	localparam logic [22:0] RECIP_1000 = 23'd4294967;
	localparam logic [9:0] MS_PER_S = 10'd1000;

	// opcodes
	localparam logic [2:0] OP_HEARTBEAT = 3'd0;
	localparam logic [2:0] OP_DRIVE = 3'd1;
	localparam logic [2:0] OP_STOP = 3'd2;
	localparam logic [2:0] OP_CLR_BUMPER = 3'd3;
	localparam logic [2:0] OP_INPUTS = 3'd4;
	localparam logic [2:0] OP_TICK = 3'd5;
	localparam logic [2:0] OP_TAKE = 3'd6;

	// config register indexes
	localparam logic [2:0] REG_LOW_BATT = 3'd0;
	localparam logic [2:0] REG_RECOV_BATT = 3'd1;
	localparam logic [2:0] REG_WATCHDOG = 3'd2;
	localparam logic [2:0] REG_LEASE = 3'd3;
	localparam logic [2:0] REG_LIN_LIMIT = 3'd4;
	localparam logic [2:0] REG_ANG_LIMIT = 3'd5;
	localparam logic [2:0] REG_LIN_ACCEL = 3'd6;
	localparam logic [2:0] REG_ANG_ACCEL = 3'd7;

	// status flag bit positions
	localparam int FB_ESTOP = 0;
	localparam int FB_CHARGER = 1;
	localparam int FB_LOWBATT = 2;
	localparam int FB_WATCHDOG = 3;
	localparam int FB_LEASE = 4;
	localparam int FB_BUMPER = 5;
	localparam int FB_WIRING = 6;
	localparam int FB_MOTOR = 7;

	typedef struct packed {
		logic [2:0] opcode;
		logic [31:0] now_ms;
		logic signed [15:0] linear_cmd;
		logic signed [15:0] angular_cmd;
		logic [7:0] bumper_mask;
		logic estop_clear;
		logic reset_pressed;
		logic charger_on;
		logic [15:0] batt_mv;
	} msi_item_t;

	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic delta_nz;
	} msi_step_t;

endpackage

### hw/rtl/msi_in_if.sv
// request channel carrying one interlock request
interface msi_in_if;
	logic valid;
	logic ready;
	logic [2:0] opcode;
	logic [31:0] now_ms;
	logic signed [15:0] linear_cmd;
	logic signed [15:0] angular_cmd;
	logic [7:0] bumper_mask;
	logic estop_clear;
	logic reset_pressed;
	logic charger_on;
	logic [15:0] batt_mv;

	modport source (output valid, opcode, now_ms, linear_cmd, angular_cmd, bumper_mask,
		estop_clear, reset_pressed, charger_on, batt_mv, input ready);
	modport sink (input valid, opcode, now_ms, linear_cmd, angular_cmd, bumper_mask,
		estop_clear, reset_pressed, charger_on, batt_mv, output ready);
endinterface

### hw/rtl/msi_out_if.sv
// result channel carrying speeds, status and the stop event
interface msi_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] applied_linear;
	logic signed [15:0] applied_angular;
	logic [7:0] status_flags;
	logic event_valid;
	logic [6:0] event_causes;
	logic [31:0] event_observed_ms;
	logic [31:0] event_enacted_ms;
	logic [15:0] event_dropped;

	modport source (output valid, applied_linear, applied_angular, status_flags, event_valid,
		event_causes, event_observed_ms, event_enacted_ms, event_dropped, input ready);
	modport sink (input valid, applied_linear, applied_angular, status_flags, event_valid,
		event_causes, event_observed_ms, event_enacted_ms, event_dropped, output ready);
endinterface

### hw/rtl/msi_slew.sv
// one slew step: rate product divided by 1000 (at least 1 if time passed), then limited to the target
module msi_slew import msi_pkg::*; (
	input logic signed [15:0] cur,
	input logic signed [15:0] tgt,
	input msi_step_t step_in,
	output logic signed [15:0] next
);
	logic big;
	logic [DELTA_W-1:0] x;
	logic [DELTA_W+22:0] recip_prod;
	logic [16:0] q0;
	logic [DELTA_W:0] rem;
	logic [16:0] q;
	logic [16:0] step;
	logic signed [16:0] diff;
	logic [16:0] mag;

	// divide by 1000: reciprocal estimate plus one correction
	always_comb begin
		big = (step_in.prod[PROD_W-1:DELTA_W] != '0);
		x = step_in.prod[DELTA_W-1:0];
		recip_prod = {23'd0, x} * {{DELTA_W{1'b0}}, RECIP_1000};
		q0 = recip_prod[48:32];
		rem = {1'b0, x} - ({10'd0, q0} * {17'd0, MS_PER_S});
		q = (rem >= {17'd0, MS_PER_S}) ? q0 + 17'd1 : q0;
		if (big) begin
			step = '1;
		end else if (q == '0 && step_in.delta_nz) begin
			step = 17'd1;
		end else begin
			step = q;
		end
	end

	// move toward target without overshoot
	always_comb begin
		diff = 17'(tgt) - 17'(cur);
		mag = diff[16] ? 17'(-diff) : 17'(diff);
		if (diff == '0) begin
			next = cur;
		end else if (step >= mag) begin
			next = tgt;
		end else if (!diff[16]) begin
			next = 16'(cur + $signed(step[15:0]));
		end else begin
			next = 16'(cur - $signed(step[15:0]));
		end
	end
endmodule

### hw/rtl/motion_safety_interlock_top.sv
// top level of the motion safety interlock
// Takes one request per clock unless the result side stalls, and returns one result per
// request, in order, through an input register, a stage that forms the tick interval and the
// two rate products, and the stage that divides, slews and updates all latches into the result
// register. Requests keep flowing while a result waits, until all three stages are full.
module motion_safety_interlock_top import msi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data,
	msi_in_if.sink cmd,
	msi_out_if.source rsp
);
	// configuration
	logic [15:0] low_batt_q, recov_batt_q, watchdog_q, lease_q, lin_accel_q, ang_accel_q;
	logic [14:0] lin_limit_q, ang_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_batt_q <= '0;
			recov_batt_q <= '0;
			watchdog_q <= 16'd500;
			lease_q <= 16'd500;
			lin_limit_q <= 15'd1000;
			ang_limit_q <= 15'd2000;
			lin_accel_q <= 16'd1000;
			ang_accel_q <= 16'd2000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW_BATT: low_batt_q <= cfg_data;
				REG_RECOV_BATT: recov_batt_q <= cfg_data;
				REG_WATCHDOG: watchdog_q <= cfg_data;
				REG_LEASE: lease_q <= cfg_data;
				REG_LIN_LIMIT: lin_limit_q <= cfg_data[14:0];
				REG_ANG_LIMIT: ang_limit_q <= cfg_data[14:0];
				REG_LIN_ACCEL: lin_accel_q <= cfg_data;
				REG_ANG_ACCEL: ang_accel_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline handshake
	logic v_s1, v_s2, out_v_q;
	logic adv_out, adv_s2, adv_s1;
	msi_item_t item_s1, item_s2, item_in;

	assign adv_out = v_s2 && (!out_v_q || rsp.ready);
	assign adv_s2 = v_s1 && (!v_s2 || adv_out);
	assign adv_s1 = cmd.valid && cmd.ready;
	assign cmd.ready = !v_s1 || adv_s2;

	always_comb begin
		item_in.opcode = cmd.opcode;
		item_in.now_ms = cmd.now_ms;
		item_in.linear_cmd = cmd.linear_cmd;
		item_in.angular_cmd = cmd.angular_cmd;
		item_in.bumper_mask = cmd.bumper_mask;
		item_in.estop_clear = cmd.estop_clear;
		item_in.reset_pressed = cmd.reset_pressed;
		item_in.charger_on = cmd.charger_on;
		item_in.batt_mv = cmd.batt_mv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= 1'b1;
			end else if (adv_s2) begin
				v_s1 <= 1'b0;
			end
			if (adv_s2) begin
				v_s2 <= 1'b1;
			end else if (adv_out) begin
				v_s2 <= 1'b0;
			end
			if (adv_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			item_s1 <= item_in;
		end
	end

	// tick interval and rate products
	logic [31:0] prev_tick_q;
	logic [31:0] delta;
	logic [DELTA_W-1:0] delta_sat;
	msi_step_t lin_step_s2, ang_step_s2;

	always_comb begin
		delta = item_s1.now_ms - prev_tick_q;
		delta_sat = (delta[31:DELTA_W] != '0) ? '1 : delta[DELTA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_tick_q <= '0;
		end else if (adv_s2 && item_s1.opcode == OP_TICK) begin
			prev_tick_q <= item_s1.now_ms;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			item_s2 <= item_s1;
			lin_step_s2.prod <= {{DELTA_W{1'b0}}, lin_accel_q} * {16'd0, delta_sat};
			ang_step_s2.prod <= {{DELTA_W{1'b0}}, ang_accel_q} * {16'd0, delta_sat};
			lin_step_s2.delta_nz <= (delta != '0);
			ang_step_s2.delta_nz <= (delta != '0);
		end
	end

	// interlock state
	logic signed [15:0] tgt_lin_q, tgt_ang_q, slew_lin_q, slew_ang_q;
	logic [31:0] hb_time_q, mot_time_q;
	logic hb_seen_q, mot_seen_q;
	logic estop_q, charger_q, lowbatt_q, charger_now_q, rst_prev_q;
	logic [7:0] bumper_q, released_q, wiring_q, flag_q;
	logic [6:0] active_q, pending_q;
	logic [31:0] pend_obs_q;
	logic evt_wait_q;
	logic [6:0] evt_causes_q;
	logic [31:0] evt_obs_q, evt_enact_q;
	logic [15:0] evt_drop_q;

	logic signed [15:0] lin_next, ang_next;
	msi_slew u_slew_lin (.cur(slew_lin_q), .tgt(tgt_lin_q), .step_in(lin_step_s2),
		.next(lin_next));
	msi_slew u_slew_ang (.cur(slew_ang_q), .tgt(tgt_ang_q), .step_in(ang_step_s2),
		.next(ang_next));

	// next-state logic for the item leaving the second stage
	logic signed [15:0] n_tgt_lin, n_tgt_ang, n_slew_lin, n_slew_ang;
	logic [31:0] n_hb_time, n_mot_time;
	logic n_hb_seen, n_mot_seen;
	logic n_estop, n_charger, n_lowbatt, n_charger_now, n_rst_prev;
	logic [7:0] n_bumper, n_released, n_wiring, n_flag;
	logic [6:0] n_active, n_pending;
	logic [31:0] n_pend_obs;
	logic n_evt_wait;
	logic [6:0] n_evt_causes;
	logic [31:0] n_evt_obs, n_evt_enact;
	logic [15:0] n_evt_drop;
	logic r_evt_valid;
	logic [6:0] r_causes;
	logic [31:0] r_obs, r_enact;
	logic [15:0] r_drop;

	logic [7:0] rel, open_bits;
	logic edge_rise, wd, ls, fault;
	logic [6:0] causes, fresh;
	logic signed [15:0] lin_lim, ang_lim;
	logic [31:0] now;

	always_comb begin
		now = item_s2.now_ms;
		n_tgt_lin = tgt_lin_q;
		n_tgt_ang = tgt_ang_q;
		n_slew_lin = slew_lin_q;
		n_slew_ang = slew_ang_q;
		n_hb_time = hb_time_q;
		n_mot_time = mot_time_q;
		n_hb_seen = hb_seen_q;
		n_mot_seen = mot_seen_q;
		n_estop = estop_q;
		n_charger = charger_q;
		n_lowbatt = lowbatt_q;
		n_charger_now = charger_now_q;
		n_rst_prev = rst_prev_q;
		n_bumper = bumper_q;
		n_released = released_q;
		n_wiring = wiring_q;
		n_flag = flag_q;
		n_active = active_q;
		n_pending = pending_q;
		n_pend_obs = pend_obs_q;
		n_evt_wait = evt_wait_q;
		n_evt_causes = evt_causes_q;
		n_evt_obs = evt_obs_q;
		n_evt_enact = evt_enact_q;
		n_evt_drop = evt_drop_q;
		r_evt_valid = 1'b0;
		r_causes = '0;
		r_obs = '0;
		r_enact = '0;
		r_drop = '0;
		lin_lim = $signed({1'b0, lin_limit_q});
		ang_lim = $signed({1'b0, ang_limit_q});
		rel = item_s2.bumper_mask & BUMPER_ALL;
		open_bits = ~rel & BUMPER_ALL;
		edge_rise = item_s2.reset_pressed && !rst_prev_q;
		wd = !hb_seen_q || ((now - hb_time_q) > {16'd0, watchdog_q});
		ls = !mot_seen_q || ((now - mot_time_q) > {16'd0, lease_q});
		fault = wd || ls || (bumper_q != '0) || estop_q || charger_q || lowbatt_q
			|| (wiring_q != '0);
		causes = '0;
		fresh = '0;

		case (item_s2.opcode)
			OP_HEARTBEAT: begin
				n_hb_time = now;
				n_hb_seen = 1'b1;
			end
			OP_DRIVE: begin
				// symmetric clamp of the requested speeds
				if (item_s2.linear_cmd > lin_lim) n_tgt_lin = lin_lim;
				else if (item_s2.linear_cmd < -lin_lim) n_tgt_lin = -lin_lim;
				else n_tgt_lin = item_s2.linear_cmd;
				if (item_s2.angular_cmd > ang_lim) n_tgt_ang = ang_lim;
				else if (item_s2.angular_cmd < -ang_lim) n_tgt_ang = -ang_lim;
				else n_tgt_ang = item_s2.angular_cmd;
				n_mot_time = now;
				n_mot_seen = 1'b1;
			end
			OP_STOP: begin
				n_tgt_lin = '0;
				n_tgt_ang = '0;
				n_slew_lin = '0;
				n_slew_ang = '0;
			end
			OP_CLR_BUMPER: begin
				n_bumper = bumper_q & ~(item_s2.bumper_mask & released_q);
			end
			OP_INPUTS: begin
				// latch faults from the sampled inputs
				n_wiring = open_bits;
				n_bumper = bumper_q | open_bits;
				n_released = rel;
				if (!item_s2.estop_clear) n_estop = 1'b1;
				n_charger_now = item_s2.charger_on;
				if (item_s2.charger_on) n_charger = 1'b1;
				if (item_s2.batt_mv != '0 && item_s2.batt_mv <= low_batt_q)
					n_lowbatt = 1'b1;
				n_rst_prev = item_s2.reset_pressed;
				// reset button rising edge clears latches only when safe
				if (edge_rise && item_s2.estop_clear && !item_s2.charger_on
					&& item_s2.batt_mv >= recov_batt_q && open_bits == '0) begin
					n_estop = 1'b0;
					n_charger = 1'b0;
					n_lowbatt = 1'b0;
					n_tgt_lin = '0;
					n_tgt_ang = '0;
					n_slew_lin = '0;
					n_slew_ang = '0;
				end
				causes[FB_ESTOP] = n_estop;
				causes[FB_CHARGER] = n_charger || n_charger_now;
				causes[FB_LOWBATT] = n_lowbatt;
				causes[FB_BUMPER] = (n_bumper != '0);
				causes[FB_WIRING] = (open_bits != '0);
				fresh = causes & ~active_q & ~pending_q;
				if (fresh != '0) begin
					if (pending_q == '0) n_pend_obs = now;
					n_pending = pending_q | fresh;
				end
			end
			OP_TICK: begin
				// timeouts, forced stop or slew, flags and event capture
				if (fault) begin
					n_tgt_lin = '0;
					n_tgt_ang = '0;
					n_slew_lin = '0;
					n_slew_ang = '0;
				end else begin
					n_slew_lin = lin_next;
					n_slew_ang = ang_next;
				end
				n_flag = '0;
				n_flag[FB_ESTOP] = estop_q;
				n_flag[FB_CHARGER] = charger_q || charger_now_q;
				n_flag[FB_LOWBATT] = lowbatt_q;
				n_flag[FB_WATCHDOG] = wd;
				n_flag[FB_LEASE] = ls;
				n_flag[FB_BUMPER] = (bumper_q != '0);
				n_flag[FB_WIRING] = (wiring_q != '0);
				n_flag[FB_MOTOR] = (n_flag[6:0] == '0);
				fresh = n_flag[6:0] & ~active_q;
				if (fresh != '0) begin
					n_evt_drop = '0;
					if (evt_wait_q) begin
						n_evt_drop = (evt_drop_q == '1) ? evt_drop_q : evt_drop_q + 16'd1;
					end
					n_evt_causes = fresh;
					n_evt_obs = ((pending_q & fresh) != '0) ? pend_obs_q : now;
					n_evt_enact = now;
					n_evt_wait = 1'b1;
				end
				n_active = n_flag[6:0];
				n_pending = '0;
			end
			OP_TAKE: begin
				if (evt_wait_q) begin
					r_evt_valid = 1'b1;
					r_causes = evt_causes_q;
					r_obs = evt_obs_q;
					r_enact = evt_enact_q;
					r_drop = evt_drop_q;
					n_evt_wait = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_lin_q <= '0;
			tgt_ang_q <= '0;
			slew_lin_q <= '0;
			slew_ang_q <= '0;
			hb_time_q <= '0;
			mot_time_q <= '0;
			hb_seen_q <= 1'b0;
			mot_seen_q <= 1'b0;
			estop_q <= 1'b1;
			charger_q <= 1'b1;
			lowbatt_q <= 1'b0;
			charger_now_q <= 1'b0;
			rst_prev_q <= 1'b0;
			bumper_q <= '0;
			released_q <= '0;
			wiring_q <= '0;
			flag_q <= '0;
			active_q <= '1;
			pending_q <= '0;
			pend_obs_q <= '0;
			evt_wait_q <= 1'b0;
			evt_causes_q <= '0;
			evt_obs_q <= '0;
			evt_enact_q <= '0;
			evt_drop_q <= '0;
		end else if (adv_out) begin
			tgt_lin_q <= n_tgt_lin;
			tgt_ang_q <= n_tgt_ang;
			slew_lin_q <= n_slew_lin;
			slew_ang_q <= n_slew_ang;
			hb_time_q <= n_hb_time;
			mot_time_q <= n_mot_time;
			hb_seen_q <= n_hb_seen;
			mot_seen_q <= n_mot_seen;
			estop_q <= n_estop;
			charger_q <= n_charger;
			lowbatt_q <= n_lowbatt;
			charger_now_q <= n_charger_now;
			rst_prev_q <= n_rst_prev;
			bumper_q <= n_bumper;
			released_q <= n_released;
			wiring_q <= n_wiring;
			flag_q <= n_flag;
			active_q <= n_active;
			pending_q <= n_pending;
			pend_obs_q <= n_pend_obs;
			evt_wait_q <= n_evt_wait;
			evt_causes_q <= n_evt_causes;
			evt_obs_q <= n_evt_obs;
			evt_enact_q <= n_evt_enact;
			evt_drop_q <= n_evt_drop;
		end
	end

	// result register
	logic signed [15:0] out_lin_q, out_ang_q;
	logic [7:0] out_flag_q;
	logic out_evt_q;
	logic [6:0] out_causes_q;
	logic [31:0] out_obs_q, out_enact_q;
	logic [15:0] out_drop_q;

	always_ff @(posedge clk) begin
		if (adv_out) begin
			out_lin_q <= n_slew_lin;
			out_ang_q <= n_slew_ang;
			out_flag_q <= n_flag;
			out_evt_q <= r_evt_valid;
			out_causes_q <= r_causes;
			out_obs_q <= r_obs;
			out_enact_q <= r_enact;
			out_drop_q <= r_drop;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.applied_linear = out_lin_q;
	assign rsp.applied_angular = out_ang_q;
	assign rsp.status_flags = out_flag_q;
	assign rsp.event_valid = out_evt_q;
	assign rsp.event_causes = out_causes_q;
	assign rsp.event_observed_ms = out_obs_q;
	assign rsp.event_enacted_ms = out_enact_q;
	assign rsp.event_dropped = out_drop_q;

	// a faulted tick leaves both speeds at zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_out && item_s2.opcode == OP_TICK && fault) |=> (slew_lin_q == '0 && slew_ang_q == '0))
		else $error("speed not zero after faulted tick");

	// a waiting event is only cleared by a take request
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(evt_wait_q) |-> $past(adv_out && item_s2.opcode == OP_TAKE))
		else $error("event lost without take");

	// a delivered event always names at least one cause
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_evt_q) |-> (out_causes_q != '0))
		else $error("event without cause");

	// motor enable excludes every stop cause
	assert property (@(posedge clk) disable iff (!arst_n)
		flag_q[FB_MOTOR] |-> (flag_q[6:0] == '0 && active_q == '0))
		else $error("motor enabled with active cause");
endmodule

### tb/msi_tb_pkg.sv
// scoreboard class predicting interlock results and checking them in order
`timescale 1ns / 100ps
package msi_tb_pkg;
	import msi_pkg::*;

	typedef struct packed {
		logic signed [15:0] applied_linear;
		logic signed [15:0] applied_angular;
		logic [7:0] status_flags;
		logic event_valid;
		logic [6:0] event_causes;
		logic [31:0] event_observed_ms;
		logic [31:0] event_enacted_ms;
		logic [15:0] event_dropped;
	} msi_result_t;

	class interlock_scoreboard;
		// configuration
		logic [15:0] low_batt, recov_batt, wd_ms, lease_ms_r;
		logic [14:0] lin_lim, ang_lim;
		logic [15:0] lin_acc, ang_acc;
		// interlock state
		int tgt_lin, tgt_ang, cur_lin, cur_ang;
		logic [31:0] hb_time, mv_time, last_tick;
		bit hb_seen, mv_seen, estop_l, chg_l, lowb_l, chg_now, rst_prev;
		logic [7:0] bump_l, released, wiring, flags;
		logic [6:0] active, pending, stored_causes;
		logic [31:0] pend_obs, stored_obs, stored_enact;
		bit ev_waiting;
		logic [15:0] stored_drop;
		msi_result_t expected_q[$];
		int mismatches;

		function new();
			reset_state();
			mismatches = 0;
		endfunction

		function void reset_state();
			low_batt = 0; recov_batt = 0; wd_ms = 500; lease_ms_r = 500;
			lin_lim = 1000; ang_lim = 2000; lin_acc = 1000; ang_acc = 2000;
			tgt_lin = 0; tgt_ang = 0; cur_lin = 0; cur_ang = 0;
			hb_time = 0; mv_time = 0; last_tick = 0;
			hb_seen = 0; mv_seen = 0; estop_l = 1; chg_l = 1; lowb_l = 0;
			chg_now = 0; rst_prev = 0;
			bump_l = 0; released = 0; wiring = 0; flags = 0;
			active = 7'h7f; pending = 0; pend_obs = 0;
			ev_waiting = 0; stored_causes = 0; stored_obs = 0; stored_enact = 0;
			stored_drop = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] v);
			case (idx)
				REG_LOW_BATT: low_batt = v;
				REG_RECOV_BATT: recov_batt = v;
				REG_WATCHDOG: wd_ms = v;
				REG_LEASE: lease_ms_r = v;
				REG_LIN_LIMIT: lin_lim = v[14:0];
				REG_ANG_LIMIT: ang_lim = v[14:0];
				REG_LIN_ACCEL: lin_acc = v;
				REG_ANG_ACCEL: ang_acc = v;
				default: ;
			endcase
		endfunction

		function int clamp(int v, int lim);
			if (v > lim) return lim;
			if (v < -lim) return -lim;
			return v;
		endfunction

		// one slew step, never past the target
		function int slew_toward(int cur, int tgt, logic [31:0] dt, logic [15:0] rate);
			longint stp;
			stp = (longint'(rate) * longint'(dt)) / 1000;
			if (stp < 1 && dt != 0) stp = 1;
			if (tgt > cur) return (longint'(cur) + stp > tgt) ? tgt : cur + int'(stp);
			if (tgt < cur) return (longint'(cur) - stp < tgt) ? tgt : cur - int'(stp);
			return cur;
		endfunction

		function void halt();
			tgt_lin = 0; tgt_ang = 0; cur_lin = 0; cur_ang = 0;
		endfunction

		function void sample_inputs(msi_item_t it);
			logic [7:0] rel, open;
			logic [6:0] causes, fresh;
			bit edge_seen;
			rel = it.bumper_mask & BUMPER_ALL;
			open = ~rel & BUMPER_ALL;
			wiring = open;
			bump_l |= open;
			released = rel;
			if (!it.estop_clear) estop_l = 1;
			chg_now = it.charger_on;
			if (it.charger_on) chg_l = 1;
			if (it.batt_mv != 0 && it.batt_mv <= low_batt) lowb_l = 1;
			edge_seen = it.reset_pressed && !rst_prev;
			rst_prev = it.reset_pressed;
			if (edge_seen && it.estop_clear && !it.charger_on &&
					it.batt_mv >= recov_batt && wiring == 0) begin
				estop_l = 0; chg_l = 0; lowb_l = 0;
				halt();
			end
			causes = 0;
			causes[FB_ESTOP] = estop_l;
			causes[FB_CHARGER] = chg_l || chg_now;
			causes[FB_LOWBATT] = lowb_l;
			causes[FB_BUMPER] = bump_l != 0;
			causes[FB_WIRING] = wiring != 0;
			fresh = causes & ~active & ~pending;
			if (fresh != 0) begin
				if (pending == 0) pend_obs = it.now_ms;
				pending |= fresh;
			end
		endfunction

		function void tick(logic [31:0] now);
			logic [31:0] dt;
			bit wd, ls;
			logic [7:0] f;
			logic [6:0] fresh;
			logic [15:0] drop;
			dt = now - last_tick;
			wd = !hb_seen || (now - hb_time) > wd_ms;
			ls = !mv_seen || (now - mv_time) > lease_ms_r;
			last_tick = now;
			if (wd || ls || bump_l != 0 || estop_l || chg_l || lowb_l || wiring != 0) halt();
			cur_lin = slew_toward(cur_lin, tgt_lin, dt, lin_acc);
			cur_ang = slew_toward(cur_ang, tgt_ang, dt, ang_acc);
			f = 0;
			f[FB_ESTOP] = estop_l;
			f[FB_CHARGER] = chg_l || chg_now;
			f[FB_LOWBATT] = lowb_l;
			f[FB_WATCHDOG] = wd;
			f[FB_LEASE] = ls;
			f[FB_BUMPER] = bump_l != 0;
			f[FB_WIRING] = wiring != 0;
			f[FB_MOTOR] = f[6:0] == 0;
			flags = f;
			fresh = f[6:0] & ~active;
			if (fresh != 0) begin
				drop = 16'd0;
				if (ev_waiting)
					drop = (stored_drop == 16'hffff) ? stored_drop : stored_drop + 16'd1;
				stored_causes = fresh;
				stored_obs = ((pending & fresh) != 0) ? pend_obs : now;
				stored_enact = now;
				stored_drop = drop;
				ev_waiting = 1;
			end
			active = f[6:0];
			pending = 0;
		endfunction

		// note an accepted request and queue its expected result
		function void note_request(msi_item_t it);
			msi_result_t r;
			r = '0;
			case (it.opcode)
				OP_HEARTBEAT: begin hb_time = it.now_ms; hb_seen = 1; end
				OP_DRIVE: begin
					tgt_lin = clamp(int'(it.linear_cmd), int'(lin_lim));
					tgt_ang = clamp(int'(it.angular_cmd), int'(ang_lim));
					mv_time = it.now_ms; mv_seen = 1;
				end
				OP_STOP: halt();
				OP_CLR_BUMPER: bump_l &= ~(it.bumper_mask & released);
				OP_INPUTS: sample_inputs(it);
				OP_TICK: tick(it.now_ms);
				OP_TAKE: if (ev_waiting) begin
					r.event_valid = 1;
					r.event_causes = stored_causes;
					r.event_observed_ms = stored_obs;
					r.event_enacted_ms = stored_enact;
					r.event_dropped = stored_drop;
					ev_waiting = 0;
				end
				default: ;
			endcase
			r.applied_linear = cur_lin[15:0];
			r.applied_angular = cur_ang[15:0];
			r.status_flags = flags;
			expected_q.push_back(r);
		endfunction

		// compare a result with the oldest expectation
		function void check_result(msi_result_t got);
			msi_result_t exp_r;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			exp_r = expected_q.pop_front();
			if (got !== exp_r) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch (exp/got): lin %0d/%0d ang %0d/%0d flags %h/%h",
						exp_r.applied_linear, got.applied_linear, exp_r.applied_angular,
						got.applied_angular, exp_r.status_flags, got.status_flags);
					$display("  ev %b/%b causes %h/%h obs %h/%h enact %h/%h drop %0d/%0d",
						exp_r.event_valid, got.event_valid, exp_r.event_causes,
						got.event_causes, exp_r.event_observed_ms, got.event_observed_ms,
						exp_r.event_enacted_ms, got.event_enacted_ms, exp_r.event_dropped,
						got.event_dropped);
				end
			end
		endfunction
	endclass
endpackage

### tb/tb_motion_safety_interlock_top.sv
// testbench top: drives requests and configuration, checks every result
`timescale 1ns / 100ps
module tb_motion_safety_interlock_top;
	import msi_pkg::*;
	import msi_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [2:0] OP_SPARE = 3'd7;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int idle_cycles = 0;
	logic [31:0] clock_ms = 0;

	msi_in_if cmd ();
	msi_out_if rsp ();
	interlock_scoreboard sb = new();

	motion_safety_interlock_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd(cmd), .rsp(rsp)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		cmd.valid = 0; cmd.opcode = '0; cmd.now_ms = '0; cmd.linear_cmd = '0;
		cmd.angular_cmd = '0; cmd.bumper_mask = '0; cmd.estop_clear = 0;
		cmd.reset_pressed = 0; cmd.charger_on = 0; cmd.batt_mv = '0;
		rsp.ready = 0;
	end

	// result side: random stalls, check on acceptance
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result({rsp.applied_linear, rsp.applied_angular, rsp.status_flags,
				rsp.event_valid, rsp.event_causes, rsp.event_observed_ms,
				rsp.event_enacted_ms, rsp.event_dropped});
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = $urandom_range(0, 4);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall == 0) rsp.ready <= 1;
			else begin
				rsp.ready <= 0;
				repeat (stall) @(negedge clk);
				rsp.ready <= 1;
			end
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send(msi_item_t it, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			cmd.valid <= 0;
			repeat (gap) @(negedge clk);
		end
		cmd.valid <= 1;
		cmd.opcode <= it.opcode; cmd.now_ms <= it.now_ms;
		cmd.linear_cmd <= it.linear_cmd; cmd.angular_cmd <= it.angular_cmd;
		cmd.bumper_mask <= it.bumper_mask; cmd.estop_clear <= it.estop_clear;
		cmd.reset_pressed <= it.reset_pressed; cmd.charger_on <= it.charger_on;
		cmd.batt_mv <= it.batt_mv;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		sb.note_request(it);
		@(negedge clk);
	endtask

	task automatic drain();
		cmd.valid <= 0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, v);
	endtask

	function automatic msi_item_t make(logic [2:0] op, logic [31:0] now);
		msi_item_t it;
		it = '0;
		it.opcode = op;
		it.now_ms = now;
		it.linear_cmd = 16'($urandom); it.angular_cmd = 16'($urandom);
		it.bumper_mask = 8'($urandom); it.estop_clear = 1'($urandom);
		it.reset_pressed = 1'($urandom); it.charger_on = 1'($urandom);
		it.batt_mv = 16'($urandom);
		return it;
	endfunction

	// healthy inputs, optionally with a reset press
	function automatic msi_item_t good_inputs(logic [31:0] now, bit press);
		msi_item_t it;
		it = make(OP_INPUTS, now);
		it.bumper_mask = 8'hff; it.estop_clear = 1; it.charger_on = 0;
		it.reset_pressed = press; it.batt_mv = 16'(12000 + $urandom_range(0, 5000));
		return it;
	endfunction

	// a well-formed run: recover, command motion, then tick and maybe fault
	task automatic healthy_session();
		int n;
		msi_item_t it;
		clock_ms += $urandom_range(1, 50);
		send(good_inputs(clock_ms, 0));
		send(good_inputs(clock_ms, 1));
		send(make(OP_CLR_BUMPER, clock_ms));
		n = $urandom_range(3, 12);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1: send(make(OP_HEARTBEAT, clock_ms));
				2, 3: send(make(OP_DRIVE, clock_ms));
				4, 5, 6: begin
					clock_ms += ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2000)
						: $urandom_range(0, 120);
					send(make(OP_TICK, clock_ms));
				end
				7: send(make(OP_TAKE, clock_ms));
				8: send(good_inputs(clock_ms, 1'($urandom_range(0, 1))));
				default: begin
					it = make(3'($urandom_range(0, 7)), clock_ms);
					send(it);
				end
			endcase
		end
	endtask

	initial begin
		msi_item_t it;
		int sent;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, every opcode, special cases
		send(make(OP_TAKE, 0));
		send(make(OP_TICK, 10));
		send(make(OP_TAKE, 10));
		it = make(OP_SPARE, 20); send(it);
		send(good_inputs(20, 1));
		send(make(OP_HEARTBEAT, 30));
		it = make(OP_DRIVE, 30); it.linear_cmd = 16'sh7fff; it.angular_cmd = 16'sh8000;
		send(it);
		send(make(OP_TICK, 40));
		send(make(OP_TICK, 41));
		send(make(OP_TICK, 41));
		send(make(OP_TICK, 32'hffff_fff0));
		it = make(OP_INPUTS, 50); it.bumper_mask = 8'h00; it.estop_clear = 0;
		it.charger_on = 1; it.batt_mv = 16'hffff; send(it);
		send(make(OP_TICK, 60));
		it = make(OP_CLR_BUMPER, 60); it.bumper_mask = 8'hff; send(it);
		send(make(OP_TAKE, 60));
		send(make(OP_STOP, 60));
		it = make(OP_HEARTBEAT, 32'hffff_ffff); send(it);
		it = make(OP_DRIVE, 32'hffff_ffff); it.linear_cmd = 16'sh8000;
		it.angular_cmd = 16'sh7fff; send(it);
		send(make(OP_TICK, 3));
		send(make(OP_TICK, 900));
		send(make(OP_TICK, 1900));
		send(make(OP_TAKE, 1900));
		drain();

		// phases over register settings, extremes included
		sent = 0;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_LOW_BATT, 16'd11000); write_reg(REG_RECOV_BATT, 16'd12000);
					write_reg(REG_WATCHDOG, 16'd300); write_reg(REG_LEASE, 16'd400);
					write_reg(REG_LIN_LIMIT, 16'd1500); write_reg(REG_ANG_LIMIT, 16'd3000);
					write_reg(REG_LIN_ACCEL, 16'd2000); write_reg(REG_ANG_ACCEL, 16'd500);
				end
				1: begin
					write_reg(REG_LOW_BATT, 16'hffff); write_reg(REG_RECOV_BATT, 16'hffff);
					write_reg(REG_WATCHDOG, 16'hffff); write_reg(REG_LEASE, 16'hffff);
					write_reg(REG_LIN_LIMIT, 16'h7fff); write_reg(REG_ANG_LIMIT, 16'hffff);
					write_reg(REG_LIN_ACCEL, 16'hffff); write_reg(REG_ANG_ACCEL, 16'hffff);
				end
				2: begin
					write_reg(REG_LOW_BATT, 16'd0); write_reg(REG_RECOV_BATT, 16'd0);
					write_reg(REG_WATCHDOG, 16'd0); write_reg(REG_LEASE, 16'd0);
					write_reg(REG_LIN_LIMIT, 16'd0); write_reg(REG_ANG_LIMIT, 16'd0);
					write_reg(REG_LIN_ACCEL, 16'd0); write_reg(REG_ANG_ACCEL, 16'd0);
				end
				default: begin
					write_reg(REG_LOW_BATT, 16'($urandom_range(0, 12000)));
					write_reg(REG_RECOV_BATT, 16'($urandom_range(0, 14000)));
					write_reg(REG_WATCHDOG, 16'($urandom_range(50, 2000)));
					write_reg(REG_LEASE, 16'($urandom_range(50, 2000)));
					write_reg(REG_LIN_LIMIT, 16'($urandom_range(1, 32767)));
					write_reg(REG_ANG_LIMIT, 16'($urandom_range(1, 32767)));
					write_reg(REG_LIN_ACCEL, 16'($urandom_range(1, 65535)));
					write_reg(REG_ANG_ACCEL, 16'($urandom_range(1, 65535)));
				end
			endcase
			while (sent < (ph + 1) * 230) begin
				if ($urandom_range(0, 4) == 0) begin
					// noise and broken sequences
					clock_ms += $urandom_range(0, 300);
					it = make(3'($urandom_range(0, 7)), clock_ms);
					send(it, $urandom_range(0, 2) == 0);
					sent++;
				end else begin
					healthy_session();
					sent += 10;
				end
				if (ph == 3 && sent % 100 < 10) drain();
			end
			drain();
		end

		drain();
		repeat (10) @(negedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

### sim.f
hw/rtl/msi_pkg.sv
hw/rtl/msi_in_if.sv
hw/rtl/msi_out_if.sv
hw/rtl/msi_slew.sv
hw/rtl/motion_safety_interlock_top.sv
tb/msi_tb_pkg.sv
tb/tb_motion_safety_interlock_top.sv
